// ===== hw/rtl/ppc_pkg.sv =====
// Shared types and constants for the PWM pulse/period capture block.
// No dependencies; used by the interfaces, the channel cell, the result
// register and the top level.
package ppc_pkg;

  // Field widths fixed by the request and result formats
  localparam int TICK_W = 16;
  localparam int CH_W   = 2;

  // Default configuration and parameter values
  localparam int                CHANNELS_DEF  = 3;
  localparam int                AGE_BITS_DEF  = 16;
  localparam logic [TICK_W-1:0] TIMEOUT_RESET = 16'd50;

  // Request function codes
  typedef enum logic [1:0] {
    FUNC_CAPTURE = 2'd0,
    FUNC_TICK    = 2'd1,
    FUNC_READ    = 2'd2,
    FUNC_CLEAR   = 2'd3
  } func_t;

  // Registered request
  typedef struct packed {
    func_t             func;
    logic [CH_W-1:0]   channel;
    logic [TICK_W-1:0] tick;
  } req_t;

  // Operation presented to every channel cell
  typedef struct packed {
    logic              fire;   // request is applied this cycle
    func_t             func;
    logic              hit;    // this cell is the addressed channel
    logic [TICK_W-1:0] tick;
  } cell_op_t;

  // Channel status after the request took effect
  typedef struct packed {
    logic [TICK_W-1:0] pulse_width;
    logic [TICK_W-1:0] period;
    logic              valid;
    logic              stale;
    logic              expect_falling;
  } chan_stat_t;

  // One result item
  typedef struct packed {
    logic [CH_W-1:0]   out_channel;
    logic [TICK_W-1:0] pulse_width;
    logic [TICK_W-1:0] period;
    logic              valid_res;
    logic              stale;
    logic              expect_falling;
  } res_t;

endpackage

// ===== hw/rtl/ppc_in_if.sv =====
// Request channel: valid/ready handshake with the capture request payload.
// Depends on ppc_pkg for field widths.
interface ppc_in_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  func;
  logic [ppc_pkg::CH_W-1:0]    channel;
  logic [ppc_pkg::TICK_W-1:0]  capture_tick;

  modport source (output valid, func, channel, capture_tick, input ready);
  modport sink   (input valid, func, channel, capture_tick, output ready);
endinterface

// ===== hw/rtl/ppc_out_if.sv =====
// Result channel: valid/ready handshake with the channel status payload.
// Depends on ppc_pkg for field widths.
interface ppc_out_if;
  logic                        valid;
  logic                        ready;
  logic [ppc_pkg::CH_W-1:0]    out_channel;
  logic [ppc_pkg::TICK_W-1:0]  pulse_width;
  logic [ppc_pkg::TICK_W-1:0]  period;
  logic                        valid_res;
  logic                        stale;
  logic                        expect_falling;

  modport source (output valid, out_channel, pulse_width, period, valid_res, stale,
                  expect_falling, input ready);
  modport sink   (input valid, out_channel, pulse_width, period, valid_res, stale,
                  expect_falling, output ready);
endinterface

// ===== hw/rtl/ppc_chan.sv =====
// State of one capture channel: edge phase, rise time, width, period,
// valid flag and edge age. Depends on ppc_pkg.
module ppc_chan #(
  parameter int AGE_BITS = ppc_pkg::AGE_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  ppc_pkg::cell_op_t            op,
  input  logic [ppc_pkg::TICK_W-1:0]   timeout,
  output ppc_pkg::chan_stat_t          stat
);

  localparam int CMP_W = (AGE_BITS > ppc_pkg::TICK_W) ? AGE_BITS : ppc_pkg::TICK_W;

  logic                        phase_r, phase_nxt;
  logic                        valid_r, valid_nxt;
  logic [ppc_pkg::TICK_W-1:0]  rise_r, rise_nxt;
  logic [ppc_pkg::TICK_W-1:0]  width_r, width_nxt;
  logic [ppc_pkg::TICK_W-1:0]  period_r, period_nxt;
  logic [AGE_BITS-1:0]         age_r, age_nxt;
  logic [ppc_pkg::TICK_W-1:0]  elapsed;

  assign elapsed = op.tick - rise_r;

  // Next state for the request in flight
  always_comb begin
    phase_nxt  = phase_r;
    valid_nxt  = valid_r;
    rise_nxt   = rise_r;
    width_nxt  = width_r;
    period_nxt = period_r;
    age_nxt    = age_r;
    if (op.fire) begin
      unique case (op.func)
        ppc_pkg::FUNC_CAPTURE: begin
          if (op.hit) begin
            if (!phase_r) begin
              // first rise after reset has no previous rise to measure from
              if (valid_r || (period_r != '0) || (rise_r != '0)) begin
                period_nxt = elapsed;
              end
              rise_nxt  = op.tick;
              phase_nxt = 1'b1;
            end else begin
              width_nxt = elapsed;
              valid_nxt = 1'b1;
              phase_nxt = 1'b0;
            end
            age_nxt = '0;
          end
        end
        ppc_pkg::FUNC_TICK: begin
          // saturating age
          if (age_r != '1) begin
            age_nxt = age_r + AGE_BITS'(1);
          end
        end
        ppc_pkg::FUNC_CLEAR: begin
          if (op.hit) begin
            valid_nxt  = 1'b0;
            width_nxt  = '0;
            period_nxt = '0;
          end
        end
        ppc_pkg::FUNC_READ: begin
        end
        default: begin
        end
      endcase
    end
  end

  // Status as it stands after the request
  always_comb begin
    stat.pulse_width    = width_nxt;
    stat.period         = period_nxt;
    stat.valid          = valid_nxt;
    stat.stale          = valid_nxt && (CMP_W'(age_nxt) > CMP_W'(timeout));
    stat.expect_falling = phase_nxt;
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= 1'b0;
      valid_r <= 1'b0;
      age_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      valid_r <= valid_nxt;
      age_r   <= age_nxt;
    end
  end

  // Measurement registers: zero after reset, read back as results
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rise_r   <= '0;
      width_r  <= '0;
      period_r <= '0;
    end else begin
      rise_r   <= rise_nxt;
      width_r  <= width_nxt;
      period_r <= period_nxt;
    end
  end

endmodule

// ===== hw/rtl/ppc_res_reg.sv =====
// Result register driving the result channel; holds a result while the
// receiver stalls. Depends on ppc_pkg and ppc_out_if.
module ppc_res_reg (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          load,
  input  ppc_pkg::res_t res,
  output logic          can_load,
  ppc_out_if.source     out_res
);

  logic          valid_r, valid_nxt;
  ppc_pkg::res_t res_r;

  // Empty, or the held result leaves this cycle
  assign can_load  = !valid_r || out_res.ready;
  assign valid_nxt = load || (valid_r && !out_res.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_res.valid          = valid_r;
  assign out_res.out_channel    = res_r.out_channel;
  assign out_res.pulse_width    = res_r.pulse_width;
  assign out_res.period         = res_r.period;
  assign out_res.valid_res      = res_r.valid_res;
  assign out_res.stale          = res_r.stale;
  assign out_res.expect_falling = res_r.expect_falling;

endmodule

// ===== hw/rtl/pwm_pulse_period_capture.sv =====
// PWM pulse width and period capture over several channels.
// Depends on ppc_pkg, ppc_in_if, ppc_out_if, ppc_chan and ppc_res_reg.
//
// Usage:
//   in_req carries one request per handshake: a capture edge with its
//   16-bit timer value, a time tick that ages every channel, a read, or a
//   clear of one channel. out_res returns exactly one status result per
//   request, for the addressed channel after the request has taken effect;
//   an unknown channel reports all-zero status.
//   cfg_we/cfg_wdata write the stale timeout (reset value 50); write it
//   only while no request is in flight.
// Timing:
//   A request is registered on acceptance; when the result register can take
//   a result, it updates the channel state and its result enters the output
//   register. Throughput one request per cycle while out_res is not stalled.
// Reset: synchronous active-low rst_n clears all channels to waiting for a
//   rising edge with zero width, period and age, and empties both stages.
// Stall: while out_res.ready is low and a result is held, the request
//   stage holds and in_req.ready drops once that stage is full too.
module pwm_pulse_period_capture #(
  parameter int CHANNELS = ppc_pkg::CHANNELS_DEF,
  parameter int AGE_BITS = ppc_pkg::AGE_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  ppc_in_if.sink                      in_req,
  ppc_out_if.source                   out_res,
  input  logic                        cfg_we,
  input  logic [ppc_pkg::TICK_W-1:0]  cfg_wdata
);

  logic                        s1_valid_r, s1_valid_nxt;
  ppc_pkg::req_t               s1_r;
  logic                        s1_adv;
  logic                        can_load;
  logic                        in_fire;
  logic [ppc_pkg::TICK_W-1:0]  timeout_r;
  ppc_pkg::chan_stat_t         stat [CHANNELS];
  ppc_pkg::chan_stat_t         sel;
  ppc_pkg::res_t               res;

  // Stale timeout register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= ppc_pkg::TIMEOUT_RESET;
    end else if (cfg_we) begin
      timeout_r <= cfg_wdata;
    end
  end

  // Request stage
  assign s1_adv       = s1_valid_r && can_load;
  assign in_req.ready = !s1_valid_r || can_load;
  assign in_fire      = in_req.valid && in_req.ready;
  assign s1_valid_nxt = in_fire || (s1_valid_r && !can_load);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_r.func    <= ppc_pkg::func_t'(in_req.func);
      s1_r.channel <= in_req.channel;
      s1_r.tick    <= in_req.capture_tick;
    end
  end

  // Channel cells
  for (genvar g = 0; g < CHANNELS; g++) begin : g_chan
    ppc_pkg::cell_op_t op;

    assign op.fire = s1_adv;
    assign op.func = s1_r.func;
    assign op.hit  = (int'(s1_r.channel) == g);
    assign op.tick = s1_r.tick;

    ppc_chan #(
      .AGE_BITS (AGE_BITS)
    ) u_chan (
      .clk     (clk),
      .rst_n   (rst_n),
      .op      (op),
      .timeout (timeout_r),
      .stat    (stat[g])
    );
  end

  // Status of the addressed channel; zero when out of range
  always_comb begin
    sel = '0;
    for (int i = 0; i < CHANNELS; i++) begin
      if (int'(s1_r.channel) == i) begin
        sel = stat[i];
      end
    end
  end

  always_comb begin
    res.out_channel    = s1_r.channel;
    res.pulse_width    = sel.pulse_width;
    res.period         = sel.period;
    res.valid_res      = sel.valid;
    res.stale          = sel.stale;
    res.expect_falling = sel.expect_falling;
  end

  // Result register
  ppc_res_reg u_res (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (s1_adv),
    .res      (res),
    .can_load (can_load),
    .out_res  (out_res)
  );

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps
// Self-checking bench for pwm_pulse_period_capture: capture, tick, read and clear requests.
// Depends on ppc_pkg, ppc_in_if, ppc_out_if and the capture RTL.

// Tracks per-channel capture state, predicts the status each request returns and
// checks returned status against the oldest prediction.
class capture_tracker;
  localparam int NCH = ppc_pkg::CHANNELS_DEF;
  localparam logic [15:0] AGE_TOP = 16'hFFFF;

  logic [15:0] stale_timeout;
  bit          armed_fall [NCH];
  logic [15:0] rise_at    [NCH];
  logic [15:0] width_q    [NCH];
  logic [15:0] period_q   [NCH];
  bit          valid_q    [NCH];
  logic [15:0] age        [NCH];

  ppc_pkg::res_t expected_status[$];
  int errors;
  int n_checked;
  int n_stale;
  int n_outside;

  function new();
    stale_timeout = ppc_pkg::TIMEOUT_RESET;
    for (int i = 0; i < NCH; i++) begin
      armed_fall[i] = 0;
      rise_at[i]    = '0;
      width_q[i]    = '0;
      period_q[i]   = '0;
      valid_q[i]    = 0;
      age[i]        = '0;
    end
  endfunction

  // Apply one accepted request to the channel state and queue its status
  function void note_request(logic [1:0] fn, logic [1:0] ch, logic [15:0] tk);
    ppc_pkg::res_t r;
    int c;
    bit hit;
    c   = ch;
    hit = (c < NCH);
    case (fn)
      ppc_pkg::FUNC_CAPTURE: if (hit) begin
        if (!armed_fall[c]) begin
          // first rise after reset leaves the period alone
          if (valid_q[c] || period_q[c] != 0 || rise_at[c] != 0)
            period_q[c] = tk - rise_at[c];
          rise_at[c]    = tk;
          armed_fall[c] = 1;
        end else begin
          width_q[c]    = tk - rise_at[c];
          valid_q[c]    = 1;
          armed_fall[c] = 0;
        end
        age[c] = '0;
      end
      ppc_pkg::FUNC_TICK: begin
        for (int i = 0; i < NCH; i++)
          if (age[i] != AGE_TOP) age[i] = age[i] + 16'd1;
      end
      ppc_pkg::FUNC_CLEAR: if (hit) begin
        // phase, rise time and age survive a clear
        valid_q[c]  = 0;
        width_q[c]  = '0;
        period_q[c] = '0;
      end
      default: ;
    endcase

    r = '0;
    r.out_channel = ch;
    if (hit) begin
      r.pulse_width    = width_q[c];
      r.period         = period_q[c];
      r.valid_res      = valid_q[c];
      r.stale          = valid_q[c] && (age[c] > stale_timeout);
      r.expect_falling = armed_fall[c];
    end
    expected_status.push_back(r);
  endfunction

  function void field_diff(string what, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      errors++;
      if (errors <= 200)
        $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, what, want, got);
      else if (errors == 201)
        $display("%0t ns: further mismatches counted but not shown", $time);
    end
  endfunction

  // Compare one returned status with the oldest prediction
  function void check_status(ppc_pkg::res_t got);
    ppc_pkg::res_t want;
    if (expected_status.size() == 0) begin
      errors++;
      $display("%0t ns: status for channel %0d returned with nothing outstanding, actual 0x%0h",
               $time, got.out_channel, got);
      return;
    end
    want = expected_status.pop_front();
    n_checked++;
    if (want.stale) n_stale++;
    if (want.out_channel >= NCH) n_outside++;
    field_diff("out_channel",    16'(want.out_channel),    16'(got.out_channel));
    field_diff("pulse_width",    want.pulse_width,         got.pulse_width);
    field_diff("period",         want.period,              got.period);
    field_diff("valid_res",      16'(want.valid_res),      16'(got.valid_res));
    field_diff("stale",          16'(want.stale),          16'(got.stale));
    field_diff("expect_falling", 16'(want.expect_falling), 16'(got.expect_falling));
  endfunction

  function void check_leftover();
    if (expected_status.size() != 0) begin
      errors += expected_status.size();
      $display("%0t ns: %0d status results never returned, oldest expected 0x%0h",
               $time, expected_status.size(), expected_status[0]);
    end
  endfunction
endclass

module tb;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [15:0] cfg_wdata;

  ppc_in_if  in_req ();
  ppc_out_if out_res ();

  pwm_pulse_period_capture uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_req),
    .out_res   (out_res),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  capture_tracker tracker = new();

  logic [15:0] timer_now;
  bit          hold_req;
  int          n_settings;

  // Clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Accepted requests feed the predictor
  always @(posedge clk) begin
    if (rst_n === 1'b1 && in_req.valid === 1'b1 && in_req.ready === 1'b1)
      tracker.note_request(in_req.func, in_req.channel, in_req.capture_tick);
  end

  // Accepted status results are checked
  always @(posedge clk) begin
    ppc_pkg::res_t got;
    if (rst_n === 1'b1 && out_res.valid === 1'b1 && out_res.ready === 1'b1) begin
      got.out_channel    = out_res.out_channel;
      got.pulse_width    = out_res.pulse_width;
      got.period         = out_res.period;
      got.valid_res      = out_res.valid_res;
      got.stale          = out_res.stale;
      got.expect_falling = out_res.expect_falling;
      tracker.check_status(got);
    end
  end

  // Result side: random stalls, ready streaks, and one long hold-off on request
  initial begin
    int roll;
    int run;
    out_res.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_req) begin
        hold_req = 0;
        out_res.ready <= 1'b0;
        repeat (150) @(posedge clk);
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 60) begin
          out_res.ready <= 1'b1;
          run = $urandom_range(1, 6);
        end else if (roll < 68) begin
          out_res.ready <= 1'b1;
          run = $urandom_range(30, 80);
        end else if (roll < 95) begin
          out_res.ready <= 1'b0;
          run = $urandom_range(1, 3);
        end else begin
          out_res.ready <= 1'b0;
          run = $urandom_range(8, 24);
        end
        repeat (run) @(posedge clk);
      end
    end
  end

  // Sender gap: mostly none or short, a few long
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  // Offer one request and wait for its handshake
  task automatic push_request(ppc_pkg::func_t fn, logic [1:0] ch, logic [15:0] tk, bit no_gap);
    int gap;
    gap = no_gap ? 0 : pick_gap();
    if (gap > 0) begin
      in_req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_req.valid        <= 1'b1;
    in_req.func         <= fn;
    in_req.channel      <= ch;
    in_req.capture_tick <= tk;
    do @(posedge clk); while (in_req.ready !== 1'b1);
  endtask

  // Stop offering and wait until every outstanding status has come back
  task automatic drain_results();
    in_req.valid <= 1'b0;
    @(posedge clk);
    while (tracker.expected_status.size() != 0) @(posedge clk);
  endtask

  // Timeout register is only written with nothing in flight
  task automatic write_timeout(logic [15:0] value);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    tracker.stale_timeout = value;
    n_settings++;
  endtask

  // Mostly edges on a running timer, one channel kept quiet so it ages out
  task automatic random_request(int quiet_ch, bit no_gap);
    int              roll;
    logic [1:0]      ch;
    ppc_pkg::func_t  fn;
    roll = $urandom_range(0, 99);
    if ($urandom_range(0, 19) == 0) begin
      ch = 2'd3;
    end else begin
      ch = 2'($urandom_range(0, 2));
      if (ch == quiet_ch && $urandom_range(0, 7) != 0) ch = 2'((quiet_ch + 1) % 3);
    end
    if ($urandom_range(0, 15) == 0) timer_now = 16'($urandom);
    else timer_now = timer_now + 16'($urandom_range(1, 300));
    if (roll < 50)      fn = ppc_pkg::FUNC_CAPTURE;
    else if (roll < 80) fn = ppc_pkg::FUNC_TICK;
    else if (roll < 92) fn = ppc_pkg::FUNC_READ;
    else if (roll < 97) fn = ppc_pkg::FUNC_CLEAR;
    else begin
      // noise: any field value at all
      fn = ppc_pkg::func_t'($urandom_range(0, 3));
      ch = 2'($urandom_range(0, 3));
      timer_now = 16'($urandom);
    end
    push_request(fn, ch, timer_now, no_gap);
  endtask

  // Run limit
  initial begin
    #2_000_000;
    $display("pwm_pulse_period_capture verification failed");
    $finish;
  end

  // Main sequence
  initial begin
    logic [15:0] timeouts [7];
    int burst;
    rst_n               <= 1'b0;
    cfg_we              <= 1'b0;
    cfg_wdata           <= ppc_pkg::TIMEOUT_RESET;
    in_req.valid        <= 1'b0;
    in_req.func         <= ppc_pkg::FUNC_READ;
    in_req.channel      <= 2'd0;
    in_req.capture_tick <= 16'd0;
    timer_now  = 16'd0;
    hold_req   = 0;
    n_settings = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: wrap-around widths, first rise, unknown channel, clears
    push_request(ppc_pkg::FUNC_READ,    2'd0, 16'h0000, 0);
    push_request(ppc_pkg::FUNC_READ,    2'd3, 16'hFFFF, 0);
    push_request(ppc_pkg::FUNC_CAPTURE, 2'd0, 16'h0000, 0);
    push_request(ppc_pkg::FUNC_CAPTURE, 2'd0, 16'hFFFF, 0);
    push_request(ppc_pkg::FUNC_CAPTURE, 2'd0, 16'h0005, 0);
    push_request(ppc_pkg::FUNC_CAPTURE, 2'd0, 16'h0003, 0);
    push_request(ppc_pkg::FUNC_CAPTURE, 2'd3, 16'hFFFF, 0);
    push_request(ppc_pkg::FUNC_CLEAR,   2'd3, 16'h0000, 0);
    push_request(ppc_pkg::FUNC_TICK,    2'd3, 16'h0000, 0);
    push_request(ppc_pkg::FUNC_CAPTURE, 2'd1, 16'h1234, 0);
    push_request(ppc_pkg::FUNC_CLEAR,   2'd0, 16'h0000, 0);
    push_request(ppc_pkg::FUNC_CAPTURE, 2'd0, 16'h0000, 0);
    push_request(ppc_pkg::FUNC_CAPTURE, 2'd0, 16'h8000, 0);
    push_request(ppc_pkg::FUNC_CAPTURE, 2'd2, 16'hAAAA, 0);
    push_request(ppc_pkg::FUNC_CAPTURE, 2'd2, 16'h5555, 0);
    push_request(ppc_pkg::FUNC_TICK,    2'd2, 16'h0000, 0);
    push_request(ppc_pkg::FUNC_TICK,    2'd1, 16'h0000, 0);
    push_request(ppc_pkg::FUNC_TICK,    2'd0, 16'h0000, 0);
    push_request(ppc_pkg::FUNC_READ,    2'd2, 16'h0000, 0);
    push_request(ppc_pkg::FUNC_READ,    2'd1, 16'h0000, 0);
    push_request(ppc_pkg::FUNC_CLEAR,   2'd2, 16'h0000, 0);
    push_request(ppc_pkg::FUNC_READ,    2'd2, 16'h0000, 0);

    // Random phases, one timeout each, zero and both ends included
    timeouts = '{16'd1, 16'd0, 16'd3, 16'd12, 16'd50, 16'hFFFF, 16'($urandom_range(2, 400))};
    for (int p = 0; p < 7; p++) begin
      write_timeout(timeouts[p]);
      burst = 0;
      for (int k = 0; k < 120; k++) begin
        // fill the pipeline against a long result hold-off, offering once it starts
        if (p == 2 && k == 40) begin
          hold_req = 1;
          in_req.valid <= 1'b0;
          wait (hold_req == 1'b0);
          burst = 60;
        end
        random_request(p % 3, burst > 0 || (p == 4 && k >= 90));
        if (burst > 0) burst--;
      end
    end

    // Large timeout: a fresh pulse on channel 2 stays fresh
    write_timeout(16'hFFFE);
    push_request(ppc_pkg::FUNC_CAPTURE, 2'd2, 16'h0100, 0);
    push_request(ppc_pkg::FUNC_CAPTURE, 2'd2, 16'h0180, 0);
    push_request(ppc_pkg::FUNC_READ, 2'd2, 16'h0000, 0);
    write_timeout(16'hFFFF);
    push_request(ppc_pkg::FUNC_READ, 2'd2, 16'h0000, 0);
    push_request(ppc_pkg::FUNC_READ, 2'd0, 16'h0000, 0);

    drain_results();
    repeat (8) @(posedge clk);
    tracker.check_leftover();

    $display("Checked %0d status results over %0d timeout settings after reset default.",
             tracker.n_checked, n_settings);
    $display("Stale reports: %0d, unknown-channel results: %0d, errors: %0d.",
             tracker.n_stale, tracker.n_outside, tracker.errors);
    if (tracker.errors == 0)
      $display("pwm_pulse_period_capture verification clean");
    else
      $display("pwm_pulse_period_capture verification failed");
    $finish;
  end
endmodule

// ===== pwm_pulse_period_capture.f =====
hw/rtl/ppc_pkg.sv
hw/rtl/ppc_in_if.sv
hw/rtl/ppc_out_if.sv
hw/rtl/ppc_chan.sv
hw/rtl/ppc_res_reg.sv
hw/rtl/pwm_pulse_period_capture.sv
bench/tb.sv
